FILE: rtl/core/rrtt_pkg.sv
package rrtt_pkg;

    localparam int SLOTS        = 16;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int TASK_W       = 13;
    localparam int SLOT_FIELD_W = 4;
    localparam int CMD_W        = 2;
    localparam int IN_DATA_W    = 16;
    localparam int IN_USER_W    = 8;
    localparam int OUT_DATA_W   = 24;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [TASK_W-1:0] task_num_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NO_TASKS  = 2'd3
    } status_t;

    // one table entry
    typedef struct packed {
        logic      alive;
        task_num_t task_num;
    } entry_t;

    // table port request
    typedef struct packed {
        logic      rd_en;
        slot_idx_t rd_addr;
        logic      wr_en;
        slot_idx_t wr_addr;
        entry_t    wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        task_num_t               selected_task;
        logic                    switched;
        status_t                 status;
    } result_t;

endpackage

FILE: rtl/core/rrtt_mem.sv
module rrtt_mem
(
    input  logic              clk,
    input  logic              rst_n,
    input  rrtt_pkg::mem_req_t req,
    output rrtt_pkg::entry_t   rd_data
);

    rrtt_pkg::entry_t             mem_reg [rrtt_pkg::SLOTS];
    rrtt_pkg::entry_t             raw_reg;
    logic [rrtt_pkg::SLOTS-1:0]   valid_reg;
    logic                         hit_reg;

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            raw_reg <= mem_reg[req.rd_addr];
        end
    end

    // per-entry written flags stand in for the cleared table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? raw_reg : '0;

endmodule

FILE: rtl/core/rrtt_seq.sv
module rrtt_seq
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rrtt_pkg::CMD_W-1:0]      in_cmd,
    input  logic                            in_player,
    input  rrtt_pkg::task_num_t             in_task,
    output rrtt_pkg::mem_req_t              mem_req,
    input  rrtt_pkg::entry_t                rd_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output rrtt_pkg::result_t               res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    localparam logic [rrtt_pkg::SLOT_W:0] SLOTS_X = (rrtt_pkg::SLOT_W + 1)'(rrtt_pkg::SLOTS);

    state_t                         state_reg;
    logic [rrtt_pkg::CMD_W-1:0]     cmd_reg;
    rrtt_pkg::task_num_t            task_reg;
    rrtt_pkg::slot_idx_t            base_reg;
    rrtt_pkg::slot_idx_t            off_reg;
    logic                           issue_reg;
    logic                           chk_reg;
    rrtt_pkg::slot_idx_t            chk_off_reg;
    rrtt_pkg::slot_idx_t            chk_addr_reg;
    logic                           chk_last_reg;
    logic                           notask_reg;
    rrtt_pkg::slot_idx_t            cur_reg;
    logic                           added_reg;
    rrtt_pkg::result_t              res_reg;

    logic [rrtt_pkg::SLOT_W:0]      sum;
    rrtt_pkg::slot_idx_t            rd_addr;
    logic                           last_off;
    rrtt_pkg::slot_idx_t            off_next;
    logic                           fin;
    logic                           add_ok;
    logic                           do_switch;
    logic                           wr_en;
    rrtt_pkg::entry_t               wr_data;
    rrtt_pkg::result_t              fin_res;

    // candidate address and walk order
    always_comb
    begin
        sum = {1'b0, base_reg} + {1'b0, off_reg};
        if (sum >= SLOTS_X)
        begin
            rd_addr = rrtt_pkg::SLOT_W'(sum - SLOTS_X);
        end
        else
        begin
            rd_addr = rrtt_pkg::SLOT_W'(sum);
        end

        case (cmd_reg)
            rrtt_pkg::CMD_ADD:
            begin
                last_off = (off_reg == rrtt_pkg::SLOT_W'(rrtt_pkg::SLOTS - 2));
                off_next = off_reg + rrtt_pkg::SLOT_W'(2);
            end
            rrtt_pkg::CMD_REMOVE:
            begin
                last_off = (off_reg == rrtt_pkg::SLOT_W'(rrtt_pkg::SLOTS - 1));
                off_next = off_reg + rrtt_pkg::SLOT_W'(1);
            end
            default:
            begin
                // other group first, then own group, current slot last
                last_off = (off_reg == '0);
                if (off_reg == rrtt_pkg::SLOT_W'(rrtt_pkg::SLOTS - 1))
                begin
                    off_next = rrtt_pkg::SLOT_W'(2);
                end
                else if (off_reg == rrtt_pkg::SLOT_W'(rrtt_pkg::SLOTS - 2))
                begin
                    off_next = '0;
                end
                else
                begin
                    off_next = off_reg + rrtt_pkg::SLOT_W'(2);
                end
            end
        endcase
    end

    // check of the entry read back
    always_comb
    begin
        fin       = 1'b0;
        add_ok    = 1'b0;
        do_switch = 1'b0;
        wr_en     = 1'b0;
        wr_data   = '0;
        fin_res   = '0;
        if (state_reg == S_WALK && chk_reg)
        begin
            case (cmd_reg)
                rrtt_pkg::CMD_ADD:
                begin
                    if (rd_data.task_num == '0)
                    begin
                        fin                   = 1'b1;
                        add_ok                = 1'b1;
                        wr_en                 = 1'b1;
                        wr_data.alive         = 1'b1;
                        wr_data.task_num      = task_reg;
                        fin_res.slot          = rrtt_pkg::SLOT_FIELD_W'(chk_addr_reg);
                        fin_res.selected_task = task_reg;
                        fin_res.status        = rrtt_pkg::ST_OK;
                    end
                    else if (chk_last_reg)
                    begin
                        fin            = 1'b1;
                        fin_res.status = rrtt_pkg::ST_FULL;
                    end
                end
                rrtt_pkg::CMD_REMOVE:
                begin
                    if (rd_data.task_num == task_reg)
                    begin
                        fin                   = 1'b1;
                        wr_en                 = 1'b1;
                        wr_data.alive         = 1'b0;
                        wr_data.task_num      = task_reg;
                        fin_res.slot          = rrtt_pkg::SLOT_FIELD_W'(chk_addr_reg);
                        fin_res.selected_task = task_reg;
                        fin_res.status        = rrtt_pkg::ST_OK;
                    end
                    else if (chk_last_reg)
                    begin
                        fin            = 1'b1;
                        fin_res.status = rrtt_pkg::ST_NOT_FOUND;
                    end
                end
                default:
                begin
                    fin_res.slot          = rrtt_pkg::SLOT_FIELD_W'(chk_addr_reg);
                    fin_res.selected_task = rd_data.task_num;
                    if (chk_off_reg == '0)
                    begin
                        fin            = 1'b1;
                        fin_res.status = notask_reg ? rrtt_pkg::ST_NO_TASKS : rrtt_pkg::ST_OK;
                    end
                    else if (rd_data.alive)
                    begin
                        fin              = 1'b1;
                        do_switch        = 1'b1;
                        fin_res.switched = 1'b1;
                        fin_res.status   = rrtt_pkg::ST_OK;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        mem_req.rd_en   = (state_reg == S_WALK) && issue_reg;
        mem_req.rd_addr = rd_addr;
        mem_req.wr_en   = wr_en;
        mem_req.wr_addr = chk_addr_reg;
        mem_req.wr_data = wr_data;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            issue_reg    <= 1'b0;
            chk_reg      <= 1'b0;
            cur_reg      <= rrtt_pkg::SLOT_W'(rrtt_pkg::SLOTS / 2);
            added_reg    <= 1'b0;
            cmd_reg      <= '0;
            task_reg     <= '0;
            base_reg     <= '0;
            off_reg      <= '0;
            chk_off_reg  <= '0;
            chk_addr_reg <= '0;
            chk_last_reg <= 1'b0;
            notask_reg   <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg  <= in_cmd;
                        task_reg <= in_task;
                        chk_reg  <= 1'b0;
                        case (in_cmd)
                            rrtt_pkg::CMD_ADD, rrtt_pkg::CMD_REMOVE:
                            begin
                                off_reg    <= '0;
                                notask_reg <= 1'b0;
                                if (in_cmd == rrtt_pkg::CMD_ADD)
                                begin
                                    base_reg <= rrtt_pkg::SLOT_W'(in_player);
                                end
                                else
                                begin
                                    base_reg <= '0;
                                end
                                if (in_task == '0)
                                begin
                                    res_reg   <= '{slot: '0, selected_task: '0, switched: 1'b0,
                                                   status: rrtt_pkg::ST_NOT_FOUND};
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    issue_reg <= 1'b1;
                                    state_reg <= S_WALK;
                                end
                            end
                            rrtt_pkg::CMD_TICK:
                            begin
                                base_reg   <= cur_reg;
                                off_reg    <= added_reg ? rrtt_pkg::SLOT_W'(1) : '0;
                                notask_reg <= !added_reg;
                                issue_reg  <= 1'b1;
                                state_reg  <= S_WALK;
                            end
                            default:
                            begin
                                res_reg   <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    if (fin)
                    begin
                        res_reg   <= fin_res;
                        issue_reg <= 1'b0;
                        chk_reg   <= 1'b0;
                        if (add_ok)
                        begin
                            added_reg <= 1'b1;
                        end
                        if (do_switch)
                        begin
                            cur_reg <= chk_addr_reg;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        chk_reg <= issue_reg;
                        if (issue_reg)
                        begin
                            chk_off_reg  <= off_reg;
                            chk_addr_reg <= rd_addr;
                            chk_last_reg <= last_off;
                            if (last_off)
                            begin
                                issue_reg <= 1'b0;
                            end
                            else
                            begin
                                off_reg <= off_next;
                            end
                        end
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/two_group_round_robin_task_table.sv
// add walks at most the slots of the player's group, remove and tick at most all slots;
// rejected or unknown commands go straight to the result without a walk
// throughput: one item at a time, the next taken once the result has been handed on and
// the sequencer is idle again; the walk reads one slot per cycle through the read port
// reset: asynchronous, active low; table reads as all free and dead, current slot
// is half the slot count, no task added yet; no clearing pass is needed
module two_group_round_robin_task_table
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // player [0], task_number [13:1], zero fill [15:14]
    input  logic [rrtt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // command [1:0], zero fill [7:2]
    input  logic [rrtt_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // slot [3:0], selected_task [16:4], switched [17], status [19:18], zero fill [23:20]
    output logic [rrtt_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    rrtt_pkg::mem_req_t                 mem_req;
    rrtt_pkg::entry_t                   rd_data;
    rrtt_pkg::result_t                  res;
    logic                               res_valid;
    logic                               res_ready;
    logic                               out_valid_reg;
    logic [rrtt_pkg::OUT_DATA_W-1:0]    out_data_reg;

    // slot table, one read and one write port
    rrtt_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // command sequencer: walks the table and does at most one write back
    rrtt_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser[rrtt_pkg::CMD_W-1:0]),
        .in_player (s_axis_tdata[0]),
        .in_task   (s_axis_tdata[rrtt_pkg::TASK_W:1]),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result register, refilled in the cycle it drains
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= {4'b0, res.status, res.switched, res.selected_task, res.slot};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: rtl/core/rrtt_checker.sv
module rrtt_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [rrtt_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    logic [1:0] out_status;
    logic       out_switched;

    assign out_status   = m_axis_tdata[19:18];
    assign out_switched = m_axis_tdata[17];

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while busy");

    // only a successful tick reports a switch
    a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_switched |-> out_status == rrtt_pkg::ST_OK)
        else $error("switch with failing status");

    // rejected commands report an empty slot
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_status == rrtt_pkg::ST_FULL || out_status == rrtt_pkg::ST_NOT_FOUND)
        |-> m_axis_tdata[16:0] == '0)
        else $error("failed command carries slot data");

endmodule

bind two_group_round_robin_task_table rrtt_checker u_rrtt_checker (.*);
